FILE: rtl/log_field_byte_encoder_unit_macros.svh
// Assertion helpers for the log field byte encoder
`ifndef LOG_FIELD_BYTE_ENCODER_UNIT_MACROS_SVH
`define LOG_FIELD_BYTE_ENCODER_UNIT_MACROS_SVH

// checked only out of reset
`define LFBE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LFBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lfbe_pkg.sv
`timescale 1ns / 1ps
package lfbe_pkg;

   localparam int LANES     = 4;
   localparam int MAX_BYTES = 9;
   localparam int CNT_W     = 4;

   localparam logic [1:0] CMD_UVARINT = 2'd0;
   localparam logic [1:0] CMD_SVARINT = 2'd1;
   localparam logic [1:0] CMD_TAG8    = 2'd2;

   localparam logic [1:0] CLS_ZERO = 2'd0;
   localparam logic [1:0] CLS_4BIT = 2'd1;
   localparam logic [1:0] CLS_8BIT = 2'd2;
   localparam logic [1:0] CLS_16BIT = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        word;
      logic signed [15:0] field_0;
      logic signed [15:0] field_1;
      logic signed [15:0] field_2;
      logic signed [15:0] field_3;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // one lane's share of the tag8 stream: nibbles left aligned
   typedef struct packed {
      logic [1:0]  cls;
      logic [15:0] nib;
      logic [2:0]  cnt;
   } lane_type;

endpackage

FILE: rtl/log_field_byte_encoder_unit.sv
`timescale 1ns / 1ps
// Log field byte encoder.
// Input channel req_: one word per command. Command 0 sends word as an
// unsigned varint, command 1 zigzag-maps it first, command 2 packs
// field_0..field_3 as a tag8 selector byte plus nibbles. Command 3 words
// are taken and dropped without output.
// Output channel rsp_: one encoded byte per word, last marks the final
// byte of an item. An item gives 1 to 5 (varint) or 1 to 9 (tag8) bytes.
// The request is registered in the input stage and then loaded into the
// output buffer, from which the first byte is offered.
// Bytes leave one at a time from the single byte
// output register; the next item is classified in the four lanes while
// the current one drains, and loads as its last byte is taken.
// A stalled rsp_ holds its byte; once the one-deep input stage is full,
// req_stall rises until the output buffer frees up.
// Reset (synchronous) empties the input stage and the output buffer.
module log_field_byte_encoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lfbe_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lfbe_pkg::rsp_type rsp_word
);
   import lfbe_pkg::*;

`include "log_field_byte_encoder_unit_macros.svh"

   lane_type [LANES-1:0] lane_res;
   lane_type [LANES-1:0] a_lane_ff;
   lane_type [LANES-1:0] a_lane_in;
   logic                 a_valid_ff;
   logic                 a_valid_in;
   logic                 a_tag_ff;
   logic                 a_tag_in;
   logic [31:0]          a_word_ff;
   logic [31:0]          a_word_in;
   logic                 load_ok;
   logic                 a_move;
   logic                 req_take;
   logic [8*MAX_BYTES-1:0] m_bytes;
   logic [CNT_W-1:0]     m_count;

   lfbe_lane u_lane0 (.value(req_word.field_0), .result(lane_res[0]));
   lfbe_lane u_lane1 (.value(req_word.field_1), .result(lane_res[1]));
   lfbe_lane u_lane2 (.value(req_word.field_2), .result(lane_res[2]));
   lfbe_lane u_lane3 (.value(req_word.field_3), .result(lane_res[3]));

   assign a_move    = a_valid_ff && load_ok;
   assign req_stall = a_valid_ff && !load_ok;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff && !a_move;
      a_tag_in   = a_tag_ff;
      a_word_in  = a_word_ff;
      a_lane_in  = a_lane_ff;
      if (req_take) begin
         a_valid_in = (req_word.command == CMD_UVARINT) ||
                      (req_word.command == CMD_SVARINT) ||
                      (req_word.command == CMD_TAG8);
         a_tag_in   = (req_word.command == CMD_TAG8);
         a_lane_in  = lane_res;
         if (req_word.command == CMD_SVARINT) begin
            a_word_in = {req_word.word[30:0], 1'b0} ^ {32{req_word.word[31]}};
         end else begin
            a_word_in = req_word.word;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_tag_ff  <= a_tag_in;
      a_word_ff <= a_word_in;
      a_lane_ff <= a_lane_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   lfbe_merge u_merge (
      .is_tag8 (a_tag_ff),
      .vword   (a_word_ff),
      .lanes   (a_lane_ff),
      .bytes   (m_bytes),
      .count   (m_count)
   );

   lfbe_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load_valid (a_valid_ff),
      .load_bytes (m_bytes),
      .load_count (m_count),
      .load_ok    (load_ok),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   `LFBE_ASSERT(a_move_gives_byte, clock, reset, a_move |=> rsp_valid, "load left output empty")
   `LFBE_ASSERT(mid_item_continues, clock, reset, (rsp_valid && !rsp_word.last && !rsp_stall) |=> rsp_valid, "item cut short")
   `LFBE_ASSERT(no_stage_overrun, clock, reset, req_take |-> (!a_valid_ff || a_move), "input stage overwritten")
   `LFBE_ASSERT_ALWAYS(reset_empties, clock, reset |=> (!rsp_valid && !a_valid_ff), "not empty after reset")

endmodule

FILE: rtl/lfbe_lane.sv
`timescale 1ns / 1ps
module lfbe_lane (
   input  logic signed [15:0] value,
   output lfbe_pkg::lane_type result
);
   import lfbe_pkg::*;

   logic fits_4;
   logic fits_8;

   // value fits when all bits above the kept field equal its sign bit
   assign fits_4 = (value[15:3] == '0) || (value[15:3] == '1);
   assign fits_8 = (value[15:7] == '0) || (value[15:7] == '1);

   always_comb begin
      if (value == '0) begin
         result.cls = CLS_ZERO;
         result.nib = '0;
         result.cnt = 3'd0;
      end else if (fits_4) begin
         result.cls = CLS_4BIT;
         result.nib = {value[3:0], 12'd0};
         result.cnt = 3'd1;
      end else if (fits_8) begin
         result.cls = CLS_8BIT;
         result.nib = {value[7:0], 8'd0};
         result.cnt = 3'd2;
      end else begin
         result.cls = CLS_16BIT;
         result.nib = value;
         result.cnt = 3'd4;
      end
   end

endmodule

FILE: rtl/lfbe_merge.sv
`timescale 1ns / 1ps
module lfbe_merge (
   input  logic                                  is_tag8,
   input  logic [31:0]                           vword,
   input  lfbe_pkg::lane_type [lfbe_pkg::LANES-1:0] lanes,
   output logic [8*lfbe_pkg::MAX_BYTES-1:0]      bytes,
   output logic [lfbe_pkg::CNT_W-1:0]            count
);
   import lfbe_pkg::*;

   logic [63:0]      stream;
   logic [4:0]       off;
   logic [7:0]       sel;
   logic [6:0]       grp [5];
   logic [7:0]       vb [5];
   logic [CNT_W-1:0] vcnt;
   logic [CNT_W-1:0] tcnt;

   always_comb begin
      stream = '0;
      off    = '0;
      for (int i = 0; i < LANES; i++) begin
         stream = stream | ({lanes[i].nib, 48'd0} >> {off, 2'b00});
         off    = off + {2'b00, lanes[i].cnt};
      end
      for (int i = 0; i < LANES; i++) begin
         sel[2*i +: 2] = lanes[i].cls;
      end
      // selector byte, then whole nibble pairs; odd count rounds up
      tcnt = CNT_W'(1) + CNT_W'((off + 5'd1) >> 1);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         grp[k] = vword[7*k +: 7];
      end
      grp[4] = {3'b000, vword[31:28]};
      if (grp[4] != '0) begin
         vcnt = CNT_W'(5);
      end else if (grp[3] != '0) begin
         vcnt = CNT_W'(4);
      end else if (grp[2] != '0) begin
         vcnt = CNT_W'(3);
      end else if (grp[1] != '0) begin
         vcnt = CNT_W'(2);
      end else begin
         vcnt = CNT_W'(1);
      end
      for (int k = 0; k < 5; k++) begin
         vb[k] = {(CNT_W'(k + 1) < vcnt), grp[k]};
      end
   end

   always_comb begin
      if (is_tag8) begin
         bytes = {sel, stream};
         count = tcnt;
      end else begin
         bytes = {vb[0], vb[1], vb[2], vb[3], vb[4], 32'd0};
         count = vcnt;
      end
   end

endmodule

FILE: rtl/lfbe_ser.sv
`timescale 1ns / 1ps
module lfbe_ser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load_valid,
   input  logic [8*lfbe_pkg::MAX_BYTES-1:0] load_bytes,
   input  logic [lfbe_pkg::CNT_W-1:0]       load_count,
   output logic                             load_ok,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lfbe_pkg::rsp_type                rsp_word
);
   import lfbe_pkg::*;

   logic [8*MAX_BYTES-1:0] buf_ff;
   logic [8*MAX_BYTES-1:0] buf_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic                   take;

   assign rsp_valid         = (cnt_ff != '0);
   assign take              = rsp_valid && !rsp_stall;
   assign rsp_word.out_byte = buf_ff[8*MAX_BYTES-1 -: 8];
   assign rsp_word.last     = (cnt_ff == CNT_W'(1));
   assign load_ok           = !rsp_valid || (rsp_word.last && !rsp_stall);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load_valid && load_ok) begin
         buf_in = load_bytes;
         cnt_in = load_count;
      end else if (take) begin
         buf_in = {buf_ff[8*MAX_BYTES-9:0], 8'd0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
